@@ src/rdwm_pkg.sv @@
// Package for the register DMA word mover: phase encoding, op and offset
// codes, and the item and result structs. No dependencies.
`timescale 1ns / 1ps

package rdwm_pkg;

   // Width of addresses, pointers and data words
   localparam int unsigned WORD_W = 32;

   // Input op codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_DATA  = 2'd2;

   // Register offsets from the base address
   localparam logic [WORD_W-1:0] OFS_SOURCE = 32'h0;
   localparam logic [WORD_W-1:0] OFS_TARGET = 32'h4;
   localparam logic [WORD_W-1:0] OFS_SIZE   = 32'h8;
   localparam logic [WORD_W-1:0] OFS_START  = 32'hc;

   // Bytes per word; pointers step by this, size drops by it
   localparam logic [WORD_W-1:0] WORD_BYTES = 32'd4;
   // Value of the start register that launches a copy
   localparam logic [WORD_W-1:0] START_GO   = 32'd1;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_READ  = 3'd1,
      PH_WAIT  = 3'd2,
      PH_WRITE = 3'd3,
      PH_DONE  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [WORD_W-1:0] bus_address;
      logic [WORD_W-1:0] write_value;
      logic [WORD_W-1:0] read_word;
   } item_type;

   typedef struct packed {
      logic              request_valid;
      logic              request_is_write;
      logic [WORD_W-1:0] request_address;
      logic [WORD_W-1:0] request_data;
      logic              irq;
      logic              busy_res;
   } result_type;

endpackage

@@ src/rdwm_if.sv @@
// Channel interfaces of the register DMA word mover: request, response and
// register write channels. Depends on rdwm_pkg.
`timescale 1ns / 1ps

interface rdwm_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 op;
   logic [rdwm_pkg::WORD_W-1:0] bus_address;
   logic [rdwm_pkg::WORD_W-1:0] write_value;
   logic [rdwm_pkg::WORD_W-1:0] read_word;

   modport source (output valid, op, bus_address, write_value, read_word, input ready);
   modport sink   (input valid, op, bus_address, write_value, read_word, output ready);
endinterface

interface rdwm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       request_valid;
   logic                       request_is_write;
   logic [rdwm_pkg::WORD_W-1:0] request_address;
   logic [rdwm_pkg::WORD_W-1:0] request_data;
   logic                       irq;
   logic                       busy_res;

   modport source (output valid, request_valid, request_is_write, request_address,
                   request_data, irq, busy_res, input ready);
   modport sink   (input valid, request_valid, request_is_write, request_address,
                   request_data, irq, busy_res, output ready);
endinterface

interface rdwm_csr_if;
   logic                       valid;
   logic                       ready;
   logic [rdwm_pkg::WORD_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ src/rdwm_engine.sv @@
// DMA engine: phase machine, pointers, size, start and held word, updated
// once per accepted transfer. Produces one result per transfer. Uses rdwm_pkg.
`timescale 1ns / 1ps

module rdwm_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  rdwm_pkg::item_type             item,
   input  logic [rdwm_pkg::WORD_W-1:0]    base_address,
   output rdwm_pkg::result_type           result
);

   rdwm_pkg::phase_type              phase_ff, phase_in;
   logic [rdwm_pkg::WORD_W-1:0]      source_ff, source_in;
   logic [rdwm_pkg::WORD_W-1:0]      target_ff, target_in;
   logic [rdwm_pkg::WORD_W-1:0]      bytes_ff, bytes_in;
   logic [rdwm_pkg::WORD_W-1:0]      start_ff, start_in;
   logic [rdwm_pkg::WORD_W-1:0]      held_ff, held_in;
   logic [rdwm_pkg::WORD_W-1:0]      offset;
   logic                             regs_open;

   assign offset    = item.bus_address - base_address;
   assign regs_open = (phase_ff == rdwm_pkg::PH_IDLE) && (start_ff == '0);

   // Next state and register updates
   always_comb begin
      phase_in  = phase_ff;
      source_in = source_ff;
      target_in = target_ff;
      bytes_in  = bytes_ff;
      start_in  = start_ff;
      held_in   = held_ff;
      case (item.op)
         rdwm_pkg::OP_WRITE: begin
            if (phase_ff == rdwm_pkg::PH_DONE) begin
               // any bus write in done clears phase, pointers, size and start
               phase_in  = rdwm_pkg::PH_IDLE;
               source_in = '0;
               target_in = '0;
               bytes_in  = '0;
               start_in  = '0;
            end else if (regs_open) begin
               if (offset == rdwm_pkg::OFS_SOURCE) begin
                  source_in = item.write_value;
               end else if (offset == rdwm_pkg::OFS_TARGET) begin
                  target_in = item.write_value;
               end else if (offset == rdwm_pkg::OFS_SIZE) begin
                  bytes_in = item.write_value;
               end else if (offset == rdwm_pkg::OFS_START) begin
                  start_in = item.write_value;
                  if (item.write_value == rdwm_pkg::START_GO && bytes_ff != '0) begin
                     phase_in = rdwm_pkg::PH_READ;
                  end
               end
            end
         end
         rdwm_pkg::OP_DATA: begin
            if (phase_ff == rdwm_pkg::PH_WAIT) begin
               held_in  = item.read_word;
               phase_in = rdwm_pkg::PH_WRITE;
            end
         end
         rdwm_pkg::OP_TICK: begin
            if (phase_ff == rdwm_pkg::PH_READ) begin
               source_in = source_ff + rdwm_pkg::WORD_BYTES;
               phase_in  = rdwm_pkg::PH_WAIT;
            end else if (phase_ff == rdwm_pkg::PH_WRITE) begin
               target_in = target_ff + rdwm_pkg::WORD_BYTES;
               // last word, ragged tail included
               if (bytes_ff <= rdwm_pkg::WORD_BYTES) begin
                  bytes_in = '0;
                  phase_in = rdwm_pkg::PH_DONE;
               end else begin
                  bytes_in = bytes_ff - rdwm_pkg::WORD_BYTES;
                  phase_in = rdwm_pkg::PH_READ;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result of this transfer
   always_comb begin
      result = '0;
      if (item.op == rdwm_pkg::OP_TICK) begin
         if (phase_ff == rdwm_pkg::PH_READ) begin
            result.request_valid   = 1'b1;
            result.request_address = source_ff;
         end else if (phase_ff == rdwm_pkg::PH_WRITE) begin
            result.request_valid    = 1'b1;
            result.request_is_write = 1'b1;
            result.request_address  = target_ff;
            result.request_data     = held_ff;
         end
      end
      result.irq      = (phase_in == rdwm_pkg::PH_DONE);
      result.busy_res = (phase_in != rdwm_pkg::PH_IDLE);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rdwm_pkg::PH_IDLE;
         source_ff <= '0;
         target_ff <= '0;
         bytes_ff  <= '0;
         start_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         source_ff <= source_in;
         target_ff <= target_in;
         bytes_ff  <= bytes_in;
         start_ff  <= start_in;
      end
   end

   // Held word is always written before use
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

@@ src/register_dma_word_mover_top.sv @@
// Top level of the register DMA word mover: base address register, engine
// and a two-entry result buffer. Uses rdwm_pkg, rdwm_if and rdwm_engine.
`timescale 1ns / 1ps

// Usage
//   req_chan: one transfer per event - a tick, a bus register write or read
//     data returned from memory. rsp_chan: exactly one result per request,
//     carrying the memory request issued (if any), irq and busy.
//   csr_chan: writes the base address of the register block; always ready.
//     Write it only while no request is in flight.
// Output: each result is registered, in the skid register while stalled.
// Throughput: one request per cycle while req is ready; all work is a
//   single register-to-register pass through compare and 32-bit add logic.
// Stall: an output register plus a skid register take results while the
//   receiver holds rsp ready low; req ready drops only when both are full
//   and comes back the cycle after the receiver drains one.
// Reset: phase idle, pointers, size, start and base address zero, result
//   buffer empty. No clearing pass is needed.
module register_dma_word_mover_top (
   input  logic             clock,
   input  logic             reset,
   rdwm_req_if.sink         req_chan,
   rdwm_rsp_if.source       rsp_chan,
   rdwm_csr_if.sink         csr_chan
);

   logic [rdwm_pkg::WORD_W-1:0] base_ff;
   rdwm_pkg::item_type          item;
   rdwm_pkg::result_type        result;
   rdwm_pkg::result_type        out_ff, skid_ff;
   logic                        out_vld_ff, skid_vld_ff;
   logic                        accept, drain;

   // Base address register
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_chan.valid) begin
         base_ff <= csr_chan.data;
      end
   end

   assign item.op          = req_chan.op;
   assign item.bus_address = req_chan.bus_address;
   assign item.write_value = req_chan.write_value;
   assign item.read_word   = req_chan.read_word;

   assign req_chan.ready = !skid_vld_ff;
   assign accept         = req_chan.valid && !skid_vld_ff;
   assign drain          = !out_vld_ff || rsp_chan.ready;

   rdwm_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .item         (item),
      .base_address (base_ff),
      .result       (result)
   );

   // Output register and skid stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (drain) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= accept;
         end else begin
            out_vld_ff  <= accept;
         end
      end else if (accept) begin
         skid_vld_ff <= 1'b1;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (drain) begin
         if (skid_vld_ff) begin
            out_ff  <= skid_ff;
            skid_ff <= result;
         end else begin
            out_ff  <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_chan.valid            = out_vld_ff;
   assign rsp_chan.request_valid    = out_ff.request_valid;
   assign rsp_chan.request_is_write = out_ff.request_is_write;
   assign rsp_chan.request_address  = out_ff.request_address;
   assign rsp_chan.request_data     = out_ff.request_data;
   assign rsp_chan.irq              = out_ff.irq;
   assign rsp_chan.busy_res         = out_ff.busy_res;

endmodule

@@ src/rdwm_checker.sv @@
// Port-level checks for the register DMA word mover, bound to the top level.
// Uses only top-level port signals.
`timescale 1ns / 1ps

module rdwm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           request_valid,
   input logic                           request_is_write,
   input logic [rdwm_pkg::WORD_W-1:0]    request_address,
   input logic [rdwm_pkg::WORD_W-1:0]    request_data,
   input logic                           irq,
   input logic                           busy_res
);

   // A stalled result stays valid and keeps its address, data and irq
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(request_address)
         && $stable(request_data) && $stable(irq))
      else $error("stalled result changed");

   // Done phase is never idle
   a_irq_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && irq |-> busy_res)
      else $error("irq without busy");

   // A write request is a request
   a_write_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && request_is_write |-> request_valid)
      else $error("write flag without request");

   // No request means zero address and data
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !request_valid |-> request_address == '0 && request_data == '0)
      else $error("payload without request");

   // Result buffer empties at reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind register_dma_word_mover_top rdwm_checker u_rdwm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .request_valid    (rsp_chan.request_valid),
   .request_is_write (rsp_chan.request_is_write),
   .request_address  (rsp_chan.request_address),
   .request_data     (rsp_chan.request_data),
   .irq              (rsp_chan.irq),
   .busy_res         (rsp_chan.busy_res)
);
